/* sv/mf3_pkg.sv */
// ----------------------------------------------------------------------------
// mf3_pkg: shared types, constants and byte-lane helpers
// Widths, register indexes, reset values and the sorting helpers used by the
// 3x3 median filter and its line-store RAM.
// ----------------------------------------------------------------------------
package mf3_pkg;

   // field widths
   localparam int PIX_W          = 32;
   localparam int CHAN_W         = 8;
   localparam int LANES          = PIX_W / CHAN_W;
   localparam int LINE_WIDTH_W   = 11;
   localparam int FRAME_HEIGHT_W = 12;
   localparam int BPP_W          = 3;
   localparam int ROW_W          = 12;
   localparam int CENTER_COL_W   = 10;
   localparam int CFG_CMP_W      = 13;

   // csr port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_LINE_WIDTH      = 2'd0,
      REG_FRAME_HEIGHT    = 2'd1,
      REG_BYTES_PER_PIXEL = 2'd2,
      REG_UNUSED          = 2'd3
   } csr_index_type;

   // reset values of the registers
   localparam logic [LINE_WIDTH_W-1:0]   LINE_WIDTH_RST   = 11'd640;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 12'd480;
   localparam logic [BPP_W-1:0]          BPP_RST          = 3'd1;

   // parameter defaults
   localparam int MAX_WIDTH_DEF = 1024;
   localparam int CHANNELS_DEF  = 4;

   // one window column, sorted per byte lane
   typedef struct packed {
      logic [PIX_W-1:0] hi;
      logic [PIX_W-1:0] md;
      logic [PIX_W-1:0] lo;
   } col_type;

   // tags that travel with a result
   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [CENTER_COL_W-1:0] col;
      logic                    last;
   } meta_type;

   function automatic logic [CHAN_W-1:0] byte_min(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [CHAN_W-1:0] byte_max(input logic [CHAN_W-1:0] a,
                                                  input logic [CHAN_W-1:0] b);
      return (a < b) ? b : a;
   endfunction

   function automatic logic [CHAN_W-1:0] byte_med3(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b,
                                                   input logic [CHAN_W-1:0] c);
      return byte_max(byte_min(a, b), byte_min(byte_max(a, b), c));
   endfunction

   function automatic logic [PIX_W-1:0] word_min3(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] r;
      for (int k = 0; k < LANES; k++) begin
         r[k*CHAN_W +: CHAN_W] = byte_min(byte_min(a[k*CHAN_W +: CHAN_W],
                                                   b[k*CHAN_W +: CHAN_W]),
                                          c[k*CHAN_W +: CHAN_W]);
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] word_max3(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] r;
      for (int k = 0; k < LANES; k++) begin
         r[k*CHAN_W +: CHAN_W] = byte_max(byte_max(a[k*CHAN_W +: CHAN_W],
                                                   b[k*CHAN_W +: CHAN_W]),
                                          c[k*CHAN_W +: CHAN_W]);
      end
      return r;
   endfunction

   function automatic logic [PIX_W-1:0] word_med3(input logic [PIX_W-1:0] a,
                                                  input logic [PIX_W-1:0] b,
                                                  input logic [PIX_W-1:0] c);
      logic [PIX_W-1:0] r;
      for (int k = 0; k < LANES; k++) begin
         r[k*CHAN_W +: CHAN_W] = byte_med3(a[k*CHAN_W +: CHAN_W],
                                           b[k*CHAN_W +: CHAN_W],
                                           c[k*CHAN_W +: CHAN_W]);
      end
      return r;
   endfunction

   function automatic col_type sort_col(input logic [PIX_W-1:0] a,
                                        input logic [PIX_W-1:0] b,
                                        input logic [PIX_W-1:0] c);
      col_type s;
      s.lo = word_min3(a, b, c);
      s.md = word_med3(a, b, c);
      s.hi = word_max3(a, b, c);
      return s;
   endfunction

endpackage

/* sv/mf3_ram.sv */
// ----------------------------------------------------------------------------
// mf3_ram: simple dual-port RAM
// One write port, one read port with registered read data (held when idle).
// ----------------------------------------------------------------------------
module mf3_ram #(
   parameter int WIDTH = mf3_pkg::PIX_W,
   parameter int DEPTH = mf3_pkg::MAX_WIDTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/median_filter_3x3.sv */
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median over raster-order pixels
// Two line-store RAMs and a two-column window build the neighborhood; the
// median is taken per byte lane through a short register pipeline.
// ----------------------------------------------------------------------------
//
//  port group | dir | handshake          | word
//  -----------+-----+--------------------+---------------------------------
//  req_       | in  | req_valid/ready    | pixel_in (4 byte lanes)
//  rsp_       | out | rsp_valid/ready    | median, center row/col, last flag
//  csr_       | in  | csr_we, no wait    | line_width/frame_height/bpp
//
//  One pixel word per clock, sustained while rsp_ is not stalled. From accept
//  to rsp_valid a word passes stage 1 (line-store read, loaded on accept),
//  column sort (stage 2), lane max/med/min (stage 3), final median (output reg).
//  Border pixels update the line stores and window but produce no word.
//  Synchronous active-high reset clears control, counters and window and loads csr reset values.
//  Each stage advances on its own; bubbles collapse, and a stall on rsp_
//  backs up stage by stage into req_ready.
//
module median_filter_3x3 #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF,
   parameter int CHANNELS  = mf3_pkg::CHANNELS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [mf3_pkg::PIX_W-1:0]           req_pixel_in,
   // median output
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [mf3_pkg::PIX_W-1:0]           rsp_median_pixel,
   output logic [mf3_pkg::ROW_W-1:0]           rsp_center_row,
   output logic [mf3_pkg::CENTER_COL_W-1:0]    rsp_center_col,
   output logic                                rsp_last_of_frame,
   // configuration
   input  logic                                csr_we,
   input  logic [mf3_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);        // column index / RAM address
   localparam int WID_W = $clog2(MAX_WIDTH + 1);    // holds the width itself
   localparam int PW    = mf3_pkg::PIX_W;
   localparam int RW    = mf3_pkg::ROW_W;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [mf3_pkg::LINE_WIDTH_W-1:0]   line_width_ff;
   logic [mf3_pkg::FRAME_HEIGHT_W-1:0] frame_height_ff;
   logic [mf3_pkg::BPP_W-1:0]          bpp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= mf3_pkg::LINE_WIDTH_RST;
         frame_height_ff <= mf3_pkg::FRAME_HEIGHT_RST;
         bpp_ff          <= mf3_pkg::BPP_RST;
      end else if (csr_we) begin
         unique case (mf3_pkg::csr_index_type'(csr_index))
            mf3_pkg::REG_LINE_WIDTH: begin
               line_width_ff <= csr_wdata[mf3_pkg::LINE_WIDTH_W-1:0];
            end
            mf3_pkg::REG_FRAME_HEIGHT: begin
               frame_height_ff <= csr_wdata[mf3_pkg::FRAME_HEIGHT_W-1:0];
            end
            mf3_pkg::REG_BYTES_PER_PIXEL: begin
               bpp_ff <= csr_wdata[mf3_pkg::BPP_W-1:0];
            end
            default: begin
               // writes to the spare index are dropped
            end
         endcase
      end
   end

   // effective (clamped) settings
   logic [mf3_pkg::CFG_CMP_W-1:0] lw_wide;
   logic [mf3_pkg::CFG_CMP_W-1:0] eff_w_wide;
   logic [WID_W-1:0]              eff_w;
   logic [RW-1:0]                 eff_h;
   logic [mf3_pkg::BPP_W-1:0]     eff_nch;
   logic [PW-1:0]                 lane_mask;

   always_comb begin
      lw_wide = mf3_pkg::CFG_CMP_W'(line_width_ff);
      if (lw_wide < mf3_pkg::CFG_CMP_W'(3)) begin
         eff_w_wide = mf3_pkg::CFG_CMP_W'(3);
      end else if (lw_wide > mf3_pkg::CFG_CMP_W'(MAX_WIDTH)) begin
         eff_w_wide = mf3_pkg::CFG_CMP_W'(MAX_WIDTH);
      end else begin
         eff_w_wide = lw_wide;
      end
      eff_w = eff_w_wide[WID_W-1:0];

      eff_h = (frame_height_ff < RW'(3)) ? RW'(3) : frame_height_ff;

      if (bpp_ff == '0) begin
         eff_nch = mf3_pkg::BPP_W'(1);
      end else if (bpp_ff > mf3_pkg::BPP_W'(CHANNELS)) begin
         eff_nch = mf3_pkg::BPP_W'(CHANNELS);
      end else begin
         eff_nch = bpp_ff;
      end

      for (int k = 0; k < mf3_pkg::LANES; k++) begin
         lane_mask[k*mf3_pkg::CHAN_W +: mf3_pkg::CHAN_W] =
            {mf3_pkg::CHAN_W{(k < CHANNELS) && (mf3_pkg::BPP_W'(k) < eff_nch)}};
      end
   end

   // ------------------------------------------------------------------
   // handshake chain: each stage loads when it is empty or drains
   // ------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_v_ff, s1_v_in;
   logic s2_v_ff, s2_v_in;
   logic s3_v_ff, s3_v_in;
   logic s1_prod_ff;
   logic out_rdy, s3_rdy, s2_rdy, s1_ret, s1_rdy, accept, s2_load;

   assign out_rdy   = !rsp_valid_ff || rsp_ready;
   assign s3_rdy    = !s3_v_ff || out_rdy;
   assign s2_rdy    = !s2_v_ff || s3_rdy;
   // border pixels retire from stage 1 without taking a slot downstream
   assign s1_ret    = s1_v_ff && (!s1_prod_ff || s2_rdy);
   assign s1_rdy    = !s1_v_ff || s1_ret;
   assign req_ready = s1_rdy;
   assign accept    = req_valid && s1_rdy;
   assign s2_load   = s1_v_ff && s1_prod_ff && s2_rdy;

   // ------------------------------------------------------------------
   // raster position of the arriving pixel
   // ------------------------------------------------------------------
   logic [COL_W-1:0] col_ff, col_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [WID_W-1:0] col_a, col_c, col_n;
   logic [RW-1:0]    row_a, row_b, row_c, row_n;
   logic             pos_prod, pos_last;

   always_comb begin
      // settings may have shrunk since the counters last moved
      if (row_ff >= eff_h) begin
         row_a = '0;
         col_a = '0;
      end else begin
         row_a = row_ff;
         col_a = WID_W'(col_ff);
      end
      row_b = row_a + RW'(1);
      if (col_a >= eff_w) begin
         col_c = '0;
         row_c = (row_b >= eff_h) ? '0 : row_b;
      end else begin
         col_c = col_a;
         row_c = row_a;
      end

      col_n = col_c + WID_W'(1);
      row_n = row_c + RW'(1);
      if (col_n >= eff_w) begin
         col_in = '0;
         row_in = (row_n >= eff_h) ? '0 : row_n;
      end else begin
         col_in = col_n[COL_W-1:0];
         row_in = row_c;
      end

      pos_prod = (row_c >= RW'(2)) && (col_c >= WID_W'(2));
      pos_last = (row_c == eff_h - RW'(1)) && (col_c == eff_w - WID_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ------------------------------------------------------------------
   // stage 1: pixel held while the line stores read column c
   // ------------------------------------------------------------------
   logic [PW-1:0]    s1_pix_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [RW-1:0]    s1_row_ff;
   logic             s1_last_ff;
   logic [PW-1:0]    upper_rd, middle_rd;
   logic [COL_W-1:0] rd_addr;

   assign rd_addr = col_c[COL_W-1:0];
   assign s1_v_in = accept ? 1'b1 : (s1_ret ? 1'b0 : s1_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s1_prod_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         if (accept) begin
            s1_prod_ff <= pos_prod;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pix_ff  <= req_pixel_in;
         s1_col_ff  <= col_c[COL_W-1:0];
         s1_row_ff  <= row_c;
         s1_last_ff <= pos_last;
      end
   end

   // row r-2: shifts up from the middle store as the middle store is refilled
   mf3_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_upper_ram (
      .clock   (clock),
      .wr_en   (s1_ret),
      .wr_addr (s1_col_ff),
      .wr_data (middle_rd),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (upper_rd)
   );

   // row r-1
   mf3_ram #(
      .WIDTH (PW),
      .DEPTH (MAX_WIDTH)
   ) u_middle_ram (
      .clock   (clock),
      .wr_en   (s1_ret),
      .wr_addr (s1_col_ff),
      .wr_data (s1_pix_ff),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (middle_rd)
   );

   // ------------------------------------------------------------------
   // window: two older columns kept already sorted per byte lane
   // ------------------------------------------------------------------
   mf3_pkg::col_type new_col;
   mf3_pkg::col_type win_a_ff, win_b_ff;     // columns c-2 and c-1
   mf3_pkg::meta_type s1_meta;
   logic [RW-1:0]    s1_row_m1;
   logic [COL_W-1:0] s1_col_m1;

   assign new_col   = mf3_pkg::sort_col(upper_rd, middle_rd, s1_pix_ff);
   assign s1_row_m1 = s1_row_ff - RW'(1);
   assign s1_col_m1 = s1_col_ff - COL_W'(1);

   always_comb begin
      s1_meta.row  = s1_row_m1;
      s1_meta.col  = mf3_pkg::CENTER_COL_W'(s1_col_m1);
      s1_meta.last = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_a_ff <= '0;
         win_b_ff <= '0;
      end else if (s1_ret) begin
         win_a_ff <= win_b_ff;
         win_b_ff <= new_col;
      end
   end

   // ------------------------------------------------------------------
   // stage 2: three sorted columns
   // ------------------------------------------------------------------
   mf3_pkg::col_type  s2_c0_ff, s2_c1_ff, s2_c2_ff;
   mf3_pkg::meta_type s2_meta_ff;

   assign s2_v_in = s2_rdy ? (s1_v_ff && s1_prod_ff) : s2_v_ff;

   always_ff @(posedge clock) begin
      if (s2_load) begin
         s2_c0_ff   <= win_a_ff;
         s2_c1_ff   <= win_b_ff;
         s2_c2_ff   <= new_col;
         s2_meta_ff <= s1_meta;
      end
   end

   // ------------------------------------------------------------------
   // stage 3: max of lows, median of mids, min of highs
   // ------------------------------------------------------------------
   logic [PW-1:0]     s3_lo_ff, s3_md_ff, s3_hi_ff;
   mf3_pkg::meta_type s3_meta_ff;

   assign s3_v_in = s3_rdy ? s2_v_ff : s3_v_ff;

   always_ff @(posedge clock) begin
      if (s3_rdy && s2_v_ff) begin
         s3_lo_ff   <= mf3_pkg::word_max3(s2_c0_ff.lo, s2_c1_ff.lo, s2_c2_ff.lo);
         s3_md_ff   <= mf3_pkg::word_med3(s2_c0_ff.md, s2_c1_ff.md, s2_c2_ff.md);
         s3_hi_ff   <= mf3_pkg::word_min3(s2_c0_ff.hi, s2_c1_ff.hi, s2_c2_ff.hi);
         s3_meta_ff <= s2_meta_ff;
      end
   end

   // ------------------------------------------------------------------
   // output register: median of the three, unused lanes zeroed
   // ------------------------------------------------------------------
   logic [PW-1:0]     out_pix_ff;
   mf3_pkg::meta_type out_meta_ff;

   assign rsp_valid_in = out_rdy ? s3_v_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff      <= 1'b0;
         s3_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_v_ff      <= s2_v_in;
         s3_v_ff      <= s3_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && s3_v_ff) begin
         out_pix_ff  <= mf3_pkg::word_med3(s3_lo_ff, s3_md_ff, s3_hi_ff) & lane_mask;
         out_meta_ff <= s3_meta_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_median_pixel  = out_pix_ff;
   assign rsp_center_row    = out_meta_ff.row;
   assign rsp_center_col    = out_meta_ff.col;
   assign rsp_last_of_frame = out_meta_ff.last;

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------
   // a line-store read never hits the entry being written in the same cycle
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (accept && s1_ret) |-> (rd_addr != s1_col_ff))
      else $error("line store read and write at same column");

   // a result word always has its center below the top border
   a_center_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_center_row != '0))
      else $error("result with center on top border");

   // the window shifts only when a pixel leaves stage 1
   a_window_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_ret |=> ($stable(win_a_ff) && $stable(win_b_ff)))
      else $error("window changed without a retiring pixel");

   // reset returns the raster counters to the frame origin
   a_reset_origin: assert property (@(posedge clock)
      reset |=> ((col_ff == '0) && (row_ff == '0) && !s1_v_ff))
      else $error("counters not cleared by reset");

endmodule

/* test/tb_median_filter_3x3.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_median_filter_3x3: self-checking bench for the 3x3 median filter
// Streams raster pixels through the req_ channel and predicts each median
// word with a behavioral copy of the line stores, window and counters. Every
// rsp_ word is checked field by field against the oldest prediction. Covers
// reset values, corner pixels, clipped register values, mid-frame register
// changes, wide clipped rows, a long output stall, random frames and a full-rate run.
// ----------------------------------------------------------------------------
module tb_median_filter_3x3;

   localparam int          PIX_W           = mf3_pkg::PIX_W;
   localparam int          CHAN_W          = mf3_pkg::CHAN_W;
   localparam int          LANES           = mf3_pkg::LANES;
   localparam int          ROW_W           = mf3_pkg::ROW_W;
   localparam int          CENTER_COL_W    = mf3_pkg::CENTER_COL_W;
   localparam int          LINE_WIDTH_W    = mf3_pkg::LINE_WIDTH_W;
   localparam int          FRAME_HEIGHT_W  = mf3_pkg::FRAME_HEIGHT_W;
   localparam int          BPP_W           = mf3_pkg::BPP_W;
   localparam int          CSR_DATA_W      = mf3_pkg::CSR_DATA_W;
   localparam int          MAX_W           = mf3_pkg::MAX_WIDTH_DEF;
   localparam int          MAX_LANES       = mf3_pkg::CHANNELS_DEF;
   localparam int          DRAIN_CYCLES    = 12;      // pipeline is 4 deep
   localparam int          RSP_HOLD_CYCLES = 300;
   localparam int          RANDOM_ITEMS    = 400;
   localparam int unsigned TIMEOUT_NS      = 50_000_000;

   // corner pixel words: all-zero, all-ones, alternating lanes, midscale, mixed lanes
   localparam logic [8:0][PIX_W-1:0] CORNER_PIXELS = {
      32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF,
      32'hFF00_FF00, 32'h8080_8080, 32'h7F7F_7F7F,
      32'h0102_0304, 32'hFEFD_FCFB, 32'h1234_5678
   };

   typedef struct packed {
      logic [PIX_W-1:0]        median;
      logic [ROW_W-1:0]        row;
      logic [CENTER_COL_W-1:0] col;
      logic                    last;
   } median_word_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid;
   logic                    req_ready;
   logic [PIX_W-1:0]        req_pixel_in;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic [PIX_W-1:0]        rsp_median_pixel;
   logic [ROW_W-1:0]        rsp_center_row;
   logic [CENTER_COL_W-1:0] rsp_center_col;
   logic                    rsp_last_of_frame;
   logic                    csr_we;
   mf3_pkg::csr_index_type  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // predictor state: register copies, line stores, window, raster counters
   logic [LINE_WIDTH_W-1:0]   cfg_width;
   logic [FRAME_HEIGHT_W-1:0] cfg_height;
   logic [BPP_W-1:0]          cfg_lanes;
   logic [PIX_W-1:0]          upper_line [MAX_W];
   logic [PIX_W-1:0]          middle_line [MAX_W];
   logic [PIX_W-1:0]          win_col [6];
   int unsigned               col_cnt;
   int unsigned               row_cnt;

   median_word_type expected_medians [$];
   median_word_type want;
   int              mismatches = 0;
   int unsigned     items_sent = 0;

   // idling controls shared with the receiver process
   logic no_idle  = 1'b0;
   logic hold_rsp = 1'b0;

   median_filter_3x3 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_pixel_in      (req_pixel_in),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_median_pixel  (rsp_median_pixel),
      .rsp_center_row    (rsp_center_row),
      .rsp_center_col    (rsp_center_col),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Register value clipping, as the block applies it
   // ---------------------------------------------------------------------
   function automatic int unsigned active_width(input logic [LINE_WIDTH_W-1:0] v);
      if (v < 3) return 3;
      if (v > MAX_W) return MAX_W;
      return v;
   endfunction

   function automatic int unsigned active_height(input logic [FRAME_HEIGHT_W-1:0] v);
      return (v < 3) ? 3 : v;
   endfunction

   function automatic int unsigned active_lanes(input logic [BPP_W-1:0] v);
      if (v < 1) return 1;
      if (v > MAX_LANES) return MAX_LANES;
      return v;
   endfunction

   // median of one byte lane over the nine window words (order is irrelevant)
   function automatic logic [CHAN_W-1:0] lane_median(input logic [8:0][PIX_W-1:0] v,
                                                     input int lane);
      logic [CHAN_W-1:0] a [9];
      logic [CHAN_W-1:0] x;
      int                j;
      for (int i = 0; i < 9; i++) a[i] = v[i][lane*CHAN_W +: CHAN_W];
      for (int i = 1; i < 9; i++) begin
         x = a[i];
         j = i - 1;
         while (j >= 0 && a[j] > x) begin
            a[j+1] = a[j];
            j--;
         end
         a[j+1] = x;
      end
      return a[4];
   endfunction

   // random pixel; a third of the time lanes are pulled toward 00/FF/midscale
   // so that ties and saturated lanes show up often
   function automatic logic [PIX_W-1:0] rand_pixel();
      logic [PIX_W-1:0] p;
      p = $urandom;
      if ($urandom_range(0, 2) == 0) begin
         for (int k = 0; k < LANES; k++) begin
            case ($urandom_range(0, 3))
               0: p[k*CHAN_W +: CHAN_W] = 8'h00;
               1: p[k*CHAN_W +: CHAN_W] = 8'hFF;
               2: p[k*CHAN_W +: CHAN_W] = 8'($urandom_range(8'h7E, 8'h81));
               default: ;
            endcase
         end
      end
      return p;
   endfunction

   // ---------------------------------------------------------------------
   // Predictor: advance raster state by one accepted pixel word and queue
   // the median word it completes, if any
   // ---------------------------------------------------------------------
   task automatic predict_pixel(input logic [PIX_W-1:0] pix);
      int unsigned            w, h, lanes, c, r;
      logic [PIX_W-1:0]       top, mid, med;
      logic [8:0][PIX_W-1:0]  nbhd;
      median_word_type        res;
      w     = active_width(cfg_width);
      h     = active_height(cfg_height);
      lanes = active_lanes(cfg_lanes);

      // counters left out of range by a register change restart the raster
      if (row_cnt >= h) begin
         row_cnt = 0;
         col_cnt = 0;
      end
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt++;
         if (row_cnt >= h) row_cnt = 0;
      end
      c = col_cnt;
      r = row_cnt;

      top = upper_line[c];
      mid = middle_line[c];

      // window centered one row up, one column left is complete
      if (r >= 2 && c >= 2) begin
         nbhd = {win_col[0], win_col[1], win_col[2], win_col[3], win_col[4],
                 win_col[5], top, mid, pix};
         med = '0;
         for (int k = 0; k < lanes; k++) med[k*CHAN_W +: CHAN_W] = lane_median(nbhd, k);
         res.median = med;
         res.row    = ROW_W'(r - 1);
         res.col    = CENTER_COL_W'(c - 1);
         res.last   = (r == h - 1) && (c == w - 1);
         expected_medians.push_back(res);
      end

      win_col[0] = win_col[3];
      win_col[1] = win_col[4];
      win_col[2] = win_col[5];
      win_col[3] = top;
      win_col[4] = mid;
      win_col[5] = pix;
      upper_line[c]  = mid;
      middle_line[c] = pix;

      col_cnt = c + 1;
      if (col_cnt >= w) begin
         col_cnt = 0;
         row_cnt = r + 1;
         if (row_cnt >= h) row_cnt = 0;
      end
   endtask

   // ---------------------------------------------------------------------
   // Channel tasks; all are entered and left at a falling edge
   // ---------------------------------------------------------------------

   // offer one pixel word; valid stays high on return so the next call can
   // follow without a bubble
   task automatic send_pixel(input logic [PIX_W-1:0] pix);
      if (!no_idle && $urandom_range(0, 7) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_valid    = 1'b1;
      req_pixel_in = pix;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_pixel(pix);
      items_sent++;
      @(negedge clock);
   endtask

   // drop valid, wait for every predicted word, then let border pixels
   // still in the pipe retire
   task automatic wait_idle();
      req_valid = 1'b0;
      while (expected_medians.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input mf3_pkg::csr_index_type idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      case (idx)
         mf3_pkg::REG_LINE_WIDTH:      cfg_width  = data[LINE_WIDTH_W-1:0];
         mf3_pkg::REG_FRAME_HEIGHT:    cfg_height = data[FRAME_HEIGHT_W-1:0];
         mf3_pkg::REG_BYTES_PER_PIXEL: cfg_lanes  = data[BPP_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic configure(input logic [CSR_DATA_W-1:0] width_val,
                            input logic [CSR_DATA_W-1:0] height_val,
                            input logic [CSR_DATA_W-1:0] lanes_val);
      wait_idle();
      write_csr(mf3_pkg::REG_LINE_WIDTH, width_val);
      write_csr(mf3_pkg::REG_FRAME_HEIGHT, height_val);
      write_csr(mf3_pkg::REG_BYTES_PER_PIXEL, lanes_val);
   endtask

   // finish the current frame so the next one starts at row 0, column 0;
   // needed before widening, since wider rows would read unwritten columns
   task automatic flush_frame();
      while (!(row_cnt == 0 && col_cnt == 0)) send_pixel(rand_pixel());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset values: part of a 640-wide row, then a cut to 3 wide moves the
   // raster to row 1; the rows after it check the 480-row height and the
   // single lane; a height cut below the row then opens a new frame
   task automatic test_reset_values();
      repeat (10) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_LINE_WIDTH, 12'd3);
      repeat (3 * 8) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_FRAME_HEIGHT, 12'd3);
      flush_frame();
   endtask

   // smallest frame, four lanes then three, extreme and mixed lane values
   task automatic test_corner_pixels();
      flush_frame();
      configure(12'd3, 12'd3, 12'd4);
      for (int i = 0; i < 9; i++) send_pixel(CORNER_PIXELS[i]);
      configure(12'd3, 12'd3, 12'd3);
      for (int i = 8; i >= 0; i--) send_pixel(CORNER_PIXELS[i]);
   endtask

   // clipped values: width/height below 3, zero lanes, too many lanes,
   // and a write to the spare index that must change nothing
   task automatic test_out_of_range_config();
      flush_frame();
      configure(12'd1, 12'd2, 12'd0);
      for (int i = 0; i < 9; i++) send_pixel(CORNER_PIXELS[i]);
      configure(12'd4, 12'd0, 12'd7);
      for (int i = 0; i < 9; i++) send_pixel(CORNER_PIXELS[i]);
      repeat (3) send_pixel(rand_pixel());
      configure(12'd3, 12'd3, 12'd2);
      write_csr(mf3_pkg::REG_UNUSED, 12'hFFF);
      for (int i = 0; i < 9; i++) send_pixel(CORNER_PIXELS[i]);
   endtask

   // register changes in the middle of a frame: lane count, a width cut
   // with the column already past it, and a height cut early in the next frame
   task automatic test_config_mid_frame();
      flush_frame();
      configure(12'd6, 12'd6, 12'd2);
      repeat (17) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_BYTES_PER_PIXEL, 12'd3);
      repeat (5) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_LINE_WIDTH, 12'd3);
      repeat (7) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_FRAME_HEIGHT, 12'd3);
      repeat (5) send_pixel(rand_pixel());
      flush_frame();
   endtask

   // wide row: a width above the maximum clips to MAX_WIDTH and lanes
   // above four clip to four; a width cut then folds the frame to 3 wide
   task automatic test_large_frames();
      flush_frame();
      configure(12'hFFF, 12'd3, 12'd5);
      repeat (160) send_pixel(rand_pixel());
      wait_idle();
      write_csr(mf3_pkg::REG_LINE_WIDTH, 12'd3);
      flush_frame();
   endtask

   // long rsp_ stall while words keep coming: the pipe fills, req_ready drops
   task automatic test_output_stall();
      flush_frame();
      configure(12'd8, 12'd30, 12'd4);
      hold_rsp = 1'b1;
      repeat (120) send_pixel(rand_pixel());
      wait_idle();
   endtask

   // random small frames; some phases cut a frame short and change
   // registers mid-frame (never widening without a frame boundary)
   task automatic test_random_frames();
      int unsigned           first, done, left, n, w, h;
      logic [CSR_DATA_W-1:0] w_raw, h_raw, b_raw;
      first = items_sent;
      while (items_sent - first < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       w_raw = 12'($urandom_range(0, 2));
            1:       w_raw = 12'($urandom_range(13, 40));
            default: w_raw = 12'($urandom_range(3, 12));
         endcase
         w_raw[CSR_DATA_W-1] = 1'($urandom_range(0, 1));   // above the register, ignored
         h_raw = ($urandom_range(0, 7) == 0) ? 12'($urandom_range(0, 2))
                                             : 12'($urandom_range(3, 10));
         b_raw = 12'($urandom);                  // upper bits are noise
         if (active_width(w_raw[LINE_WIDTH_W-1:0]) > active_width(cfg_width) ||
             $urandom_range(0, 3) != 0)
            flush_frame();
         no_idle = ($urandom_range(0, 4) == 0);
         configure(w_raw, h_raw, b_raw);
         w = active_width(cfg_width);
         h = active_height(cfg_height);
         n = $urandom_range(1, 2) * w * h;
         if ($urandom_range(0, 2) == 0) n = $urandom_range(1, w * h);
         done = items_sent - first;
         left = (done < RANDOM_ITEMS) ? RANDOM_ITEMS - done : 0;
         if (n > left) n = left;
         repeat (n) send_pixel(rand_pixel());
      end
   endtask

   // back-to-back words with no idling on either side through the end
   task automatic test_full_rate();
      no_idle = 1'b1;
      flush_frame();
      configure(12'd16, 12'd6, 12'd4);
      repeat (2 * 16 * 6) send_pixel(rand_pixel());
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stall bursts, plus one long counted hold on request
   // ---------------------------------------------------------------------
   initial begin
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (RSP_HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!no_idle && $urandom_range(0, 5) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Checker: every accepted rsp_ word against the oldest prediction
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_medians.size() == 0) begin
            $error("unexpected median word: median_pixel %h row %0d col %0d",
                   rsp_median_pixel, rsp_center_row, rsp_center_col);
            mismatches++;
         end else begin
            want = expected_medians.pop_front();
            if (rsp_median_pixel !== want.median) begin
               $error("median_pixel: expected %h, actual %h", want.median, rsp_median_pixel);
               mismatches++;
            end
            if (rsp_center_row !== want.row) begin
               $error("center_row: expected %0d, actual %0d", want.row, rsp_center_row);
               mismatches++;
            end
            if (rsp_center_col !== want.col) begin
               $error("center_col: expected %0d, actual %0d", want.col, rsp_center_col);
               mismatches++;
            end
            if (rsp_last_of_frame !== want.last) begin
               $error("last_of_frame: expected %b, actual %b", want.last,
                      rsp_last_of_frame);
               mismatches++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      req_valid    = 1'b0;
      req_pixel_in = '0;
      csr_we       = 1'b0;
      csr_index    = mf3_pkg::REG_LINE_WIDTH;
      csr_wdata    = '0;

      // predictor starts from the reset state of the block
      cfg_width  = mf3_pkg::LINE_WIDTH_RST;
      cfg_height = mf3_pkg::FRAME_HEIGHT_RST;
      cfg_lanes  = mf3_pkg::BPP_RST;
      for (int i = 0; i < MAX_W; i++) begin
         upper_line[i]  = '0;
         middle_line[i] = '0;
      end
      for (int i = 0; i < 6; i++) win_col[i] = '0;
      col_cnt = 0;
      row_cnt = 0;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      test_reset_values();
      test_corner_pixels();
      test_out_of_range_config();
      test_config_mid_frame();
      test_large_frames();
      test_output_stall();
      test_random_frames();
      test_full_rate();

      wait_idle();
      if (mismatches == 0 && expected_medians.size() == 0)
         $display("PASS median_filter_3x3");
      else
         $display("FAIL median_filter_3x3");
      $finish;
   end

   // watchdog: a hung handshake or a missing word ends here
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL median_filter_3x3");
      $finish;
   end

endmodule
